FILE: hdl/erc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the elevator request controller.
// No dependencies; erc_queue and the top level in hdl/ import this package.
package erc_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Floor range
    localparam int          FLOOR_W     = 4;
    localparam int          TOP_FLOOR   = 9;
    localparam logic [3:0]  FLOOR_TOP   = 4'(TOP_FLOOR);
    localparam logic [3:0]  FLOOR_FIRST = 4'd1;

    // Wait counter saturates here
    localparam logic [4:0]  WAIT_MAX = 5'd31;

    // Car modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_MOVING = 2'd1;
    localparam logic [1:0] MODE_HELD   = 2'd2;
    localparam logic [1:0] MODE_FORCE  = 2'd3;

    // Request types
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_KEY     = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;
    localparam logic [1:0] REQ_TIMEOUT = 2'd3;

    // Key codes (ASCII)
    localparam logic [7:0] KEY_ZERO  = 8'h30;
    localparam logic [7:0] KEY_ONE   = 8'h31;
    localparam logic [7:0] KEY_NINE  = 8'h39;
    localparam logic [7:0] KEY_CLOSE = 8'h43;
    localparam logic [7:0] KEY_HOLD  = 8'h44;

    // Green lamp patterns
    localparam logic [1:0] PAT_NONE    = 2'd0;
    localparam logic [1:0] PAT_ARRIVAL = 2'd1;
    localparam logic [1:0] PAT_DROPOFF = 2'd2;

    // Reset value of idle_ticks
    localparam logic [3:0] IDLE_TICKS_RST = 4'd4;

    // Control from the car logic to the request queue
    typedef struct packed {
        logic               push;
        logic               pop;
        logic [FLOOR_W-1:0] data;
    } t_queue_ctrl;

    // Status from the request queue
    typedef struct packed {
        logic [FLOOR_W-1:0] head;
        logic [CNT_W-1:0]   count;
    } t_queue_stat;

    // One result word
    typedef struct packed {
        logic [3:0] floor_now;
        logic       going_down;
        logic [1:0] motion_mode;
        logic       green_on;
        logic       red_on;
        logic       yellow_on;
        logic       buzzer_on;
        logic [1:0] green_pattern;
        logic [4:0] pending_count;
        logic       request_dropped;
    } t_result;

endpackage

FILE: hdl/erc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request words and result words.
// Standalone; field widths follow erc_pkg's result layout.
interface erc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] key_code;

    modport source (output valid, output req_type, output key_code, input ready);
    modport sink   (input valid, input req_type, input key_code, output ready);
endinterface

interface erc_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] floor_now;
    logic       going_down;
    logic [1:0] motion_mode;
    logic       green_on;
    logic       red_on;
    logic       yellow_on;
    logic       buzzer_on;
    logic [1:0] green_pattern;
    logic [4:0] pending_count;
    logic       request_dropped;

    modport source (
        output valid, output floor_now, output going_down, output motion_mode,
        output green_on, output red_on, output yellow_on, output buzzer_on,
        output green_pattern, output pending_count, output request_dropped,
        input  ready
    );
    modport sink (
        input  valid, input floor_now, input going_down, input motion_mode,
        input  green_on, input red_on, input yellow_on, input buzzer_on,
        input  green_pattern, input pending_count, input request_dropped,
        output ready
    );
endinterface

FILE: hdl/erc_queue.sv
`timescale 1ns / 1ps
// Circular request FIFO of floor numbers, head readable in the same cycle.
// Depends on erc_pkg (depth, widths, control/status structs).
module erc_queue
    import erc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_ctrl i_ctrl,
    output t_queue_stat o_stat
);

    logic [FLOOR_W-1:0] r_store [QUEUE_DEPTH];
    logic [IDX_W-1:0]   r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]   r_count,  n_count;

    // Pointer wrap and occupancy
    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        if (i_ctrl.push) begin
            n_wr_idx = (r_wr_idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
        end
        if (i_ctrl.pop) begin
            n_rd_idx = (r_rd_idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
        end
        case ({i_ctrl.push, i_ctrl.pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_store[r_wr_idx] <= i_ctrl.data;
        end
    end

    assign o_stat.head  = r_store[r_rd_idx];
    assign o_stat.count = r_count;

endmodule

FILE: hdl/elevator_request_controller_top.sv
`timescale 1ns / 1ps
// Elevator request controller top level: car state, lamps and result register.
// Depends on erc_pkg, erc_req_if / erc_res_if and erc_queue.
// A result word is registered and valid in the cycle after its request word is taken.
// Throughput: one word per cycle; ready drops only while a held result stalls.
// Reset (synchronous, active low): car at floor 1 heading up, idle, queue empty,
// lamps off, idle_ticks back to 4, result register empty.
module elevator_request_controller_top
    import erc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [3:0]       i_cfg_wr_data,
    erc_req_if.sink          i_req,
    erc_res_if.source        o_res
);

    // Config register
    logic [3:0] r_idle_ticks;

    // Car state
    logic [3:0] r_floor,    n_floor;
    logic [3:0] r_target,   n_target;
    logic       r_down,     n_down;
    logic [1:0] r_mode,     n_mode;
    logic [4:0] r_wait,     n_wait;
    logic       r_pickup,   n_pickup;
    logic       r_carry,    n_carry;
    logic       r_arrived,  n_arrived;
    logic       r_green,    n_green;
    logic       r_red,      n_red;
    logic       r_yellow,   n_yellow;
    logic       r_buzz,     n_buzz;

    // Result register
    logic       r_res_valid;
    t_result    r_res, n_res;

    logic        take;
    logic [1:0]  pattern;
    logic        dropped;
    logic [3:0]  key_floor;
    logic        key_is_floor;
    logic        pushing;
    logic        popping;
    t_queue_ctrl q_ctrl;
    t_queue_stat q_stat;

    assign i_req.ready = !r_res_valid || o_res.ready;
    assign take        = i_req.valid && i_req.ready;

    erc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .o_stat  (q_stat)
    );

    assign key_is_floor = (i_req.key_code >= KEY_ONE) && (i_req.key_code <= KEY_NINE);
    assign key_floor    = 4'(i_req.key_code - KEY_ZERO);

    // Next car state for the word being taken
    always_comb begin
        n_floor   = r_floor;
        n_target  = r_target;
        n_down    = r_down;
        n_mode    = r_mode;
        n_wait    = r_wait;
        n_pickup  = r_pickup;
        n_carry   = r_carry;
        n_arrived = r_arrived;
        n_green   = r_green;
        n_red     = r_red;
        n_yellow  = r_yellow;
        n_buzz    = r_buzz;
        pattern   = PAT_NONE;
        dropped   = 1'b0;
        pushing   = 1'b0;
        popping   = 1'b0;

        case (i_req.req_type)
            REQ_TICK: begin
                // Arrival handling: show pattern, or pop the next target
                if (r_floor == r_target && q_stat.count == '0) begin
                    n_red = 1'b0;
                    if (r_carry) begin
                        n_carry = 1'b0;
                        n_green = 1'b1;
                        pattern = PAT_DROPOFF;
                    end else if (!r_arrived) begin
                        n_green   = 1'b0;
                        n_arrived = 1'b1;
                        pattern   = PAT_ARRIVAL;
                    end
                end else if (r_floor == r_target) begin
                    n_red    = 1'b0;
                    n_target = q_stat.head;
                    popping  = 1'b1;
                    if (q_stat.head > r_floor) begin
                        n_down = 1'b0;
                        n_mode = MODE_IDLE;
                    end else if (q_stat.head < r_floor) begin
                        n_down = 1'b1;
                        n_mode = MODE_IDLE;
                    end
                    if (r_pickup) begin
                        n_carry  = 1'b1;
                        n_pickup = 1'b0;
                    end else begin
                        n_pickup = 1'b1;
                    end
                    n_green   = 1'b0;
                    n_arrived = 1'b0;
                end

                // Step one floor toward the target
                if (r_floor != n_target && n_mode == MODE_MOVING) begin
                    if (!n_down) begin
                        if (r_floor < FLOOR_TOP) n_floor = r_floor + 1'b1;
                    end else begin
                        if (r_floor > FLOOR_FIRST) n_floor = r_floor - 1'b1;
                    end
                    n_red   = !n_carry;
                    n_green = 1'b0;
                end

                // Pending force close warns and restarts motion
                if (n_mode == MODE_FORCE) begin
                    n_green  = 1'b0;
                    n_red    = 1'b0;
                    n_yellow = 1'b1;
                    n_buzz   = 1'b1;
                    n_mode   = MODE_MOVING;
                end else begin
                    n_yellow = 1'b0;
                    n_buzz   = 1'b0;
                end

                // Idle delay before the car starts moving
                if (n_mode == MODE_IDLE) begin
                    if (r_wait > {1'b0, r_idle_ticks}) begin
                        n_mode = MODE_MOVING;
                        n_wait = 5'd1;
                    end else if (r_wait < WAIT_MAX) begin
                        n_wait = r_wait + 1'b1;
                    end
                end
            end
            REQ_KEY: begin
                if (key_is_floor) begin
                    if (key_floor <= FLOOR_TOP) begin
                        if (q_stat.count >= CNT_W'(QUEUE_DEPTH)) begin
                            dropped = 1'b1;
                        end else begin
                            pushing = 1'b1;
                        end
                    end
                end else if (i_req.key_code == KEY_HOLD) begin
                    n_mode = MODE_HELD;
                end else if (i_req.key_code == KEY_CLOSE) begin
                    n_mode = MODE_MOVING;
                    n_wait = '0;
                end
            end
            REQ_RELEASE: begin
                if (r_mode == MODE_HELD || r_mode == MODE_FORCE) n_mode = MODE_MOVING;
            end
            default: begin
                if (r_mode == MODE_HELD) n_mode = MODE_FORCE;
            end
        endcase
    end

    assign q_ctrl.push = take && pushing;
    assign q_ctrl.pop  = take && popping;
    assign q_ctrl.data = key_floor;

    // Result word assembled from the next state
    always_comb begin
        n_res.floor_now       = n_floor;
        n_res.going_down      = n_down;
        n_res.motion_mode     = n_mode;
        n_res.green_on        = n_green;
        n_res.red_on          = n_red;
        n_res.yellow_on       = n_yellow;
        n_res.buzzer_on       = n_buzz;
        n_res.green_pattern   = pattern;
        n_res.pending_count   = 5'(q_stat.count + CNT_W'(pushing) - CNT_W'(popping));
        n_res.request_dropped = dropped;
    end

    // Config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_ticks <= IDLE_TICKS_RST;
        end else if (i_cfg_wr_en) begin
            r_idle_ticks <= i_cfg_wr_data;
        end
    end

    // Car state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor   <= FLOOR_FIRST;
            r_target  <= FLOOR_FIRST;
            r_down    <= 1'b0;
            r_mode    <= MODE_IDLE;
            r_wait    <= '0;
            r_pickup  <= 1'b0;
            r_carry   <= 1'b0;
            r_arrived <= 1'b0;
            r_green   <= 1'b0;
            r_red     <= 1'b0;
            r_yellow  <= 1'b0;
            r_buzz    <= 1'b0;
        end else if (take) begin
            r_floor   <= n_floor;
            r_target  <= n_target;
            r_down    <= n_down;
            r_mode    <= n_mode;
            r_wait    <= n_wait;
            r_pickup  <= n_pickup;
            r_carry   <= n_carry;
            r_arrived <= n_arrived;
            r_green   <= n_green;
            r_red     <= n_red;
            r_yellow  <= n_yellow;
            r_buzz    <= n_buzz;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_res_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid           = r_res_valid;
    assign o_res.floor_now       = r_res.floor_now;
    assign o_res.going_down      = r_res.going_down;
    assign o_res.motion_mode     = r_res.motion_mode;
    assign o_res.green_on        = r_res.green_on;
    assign o_res.red_on          = r_res.red_on;
    assign o_res.yellow_on       = r_res.yellow_on;
    assign o_res.buzzer_on       = r_res.buzzer_on;
    assign o_res.green_pattern   = r_res.green_pattern;
    assign o_res.pending_count   = r_res.pending_count;
    assign o_res.request_dropped = r_res.request_dropped;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for elevator_request_controller_top: random and directed
// request words against a cycle-free car predictor. Needs erc_pkg, erc_if and the RTL.
module testbench;
    import erc_pkg::*;

    localparam int STALL_LIMIT  = 500;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 7;
    localparam int PHASE_WORDS  = 207;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] key;
    } t_car_event;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [3:0] i_cfg_wr_data;

    erc_req_if req_ch();
    erc_res_if res_ch();

    elevator_request_controller_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_ch),
        .o_res         (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and expected result words
    t_car_event car_events[$];
    t_result    car_reports_due[$];

    int mismatches   = 0;
    int reports_seen = 0;
    int tx_wait, rx_wait;
    int tx_calm = 0;
    int rx_calm = 0;
    int idle_cycles;

    // Predicted car state
    logic [3:0] floor_calls [QUEUE_DEPTH];
    logic [3:0] wr_ptr, rd_ptr;
    logic [4:0] backlog;
    logic [3:0] car_at, car_goal;
    logic       car_down;
    logic [1:0] car_mode;
    logic [4:0] idle_run;
    logic       pickup_half, has_riders, arrival_done;
    logic       lamp_g, lamp_r, lamp_y, lamp_bz;
    logic [3:0] idle_limit;

    // Advance the car by one request word and return the word it should report
    function automatic t_result advance_car(input logic [1:0] kind, input logic [7:0] key);
        t_result    r;
        logic [1:0] pat;
        logic       drop;
        logic [3:0] fl;
        pat  = PAT_NONE;
        drop = 1'b0;
        case (kind)
            REQ_TICK: begin
                if (car_at == car_goal && backlog == 0) begin
                    // parked with nothing queued: show arrival or drop-off once
                    lamp_r = 1'b0;
                    if (has_riders) begin
                        has_riders = 1'b0;
                        lamp_g     = 1'b1;
                        pat        = PAT_DROPOFF;
                    end else if (!arrival_done) begin
                        lamp_g       = 1'b0;
                        arrival_done = 1'b1;
                        pat          = PAT_ARRIVAL;
                    end
                end else if (car_at == car_goal) begin
                    // take the next call off the queue
                    lamp_r   = 1'b0;
                    car_goal = floor_calls[rd_ptr];
                    if (car_goal > car_at) begin
                        car_down = 1'b0;
                        car_mode = MODE_IDLE;
                    end else if (car_goal < car_at) begin
                        car_down = 1'b1;
                        car_mode = MODE_IDLE;
                    end
                    rd_ptr  = 4'((rd_ptr + 1) % QUEUE_DEPTH);
                    backlog = backlog - 5'd1;
                    if (pickup_half) begin
                        has_riders  = 1'b1;
                        pickup_half = 1'b0;
                    end else begin
                        pickup_half = 1'b1;
                    end
                    lamp_g       = 1'b0;
                    arrival_done = 1'b0;
                end
                // one floor per tick, clamped to the shaft
                if (car_at != car_goal && car_mode == MODE_MOVING) begin
                    if (!car_down) begin
                        if (car_at < FLOOR_TOP) car_at = car_at + 4'd1;
                    end else if (car_at > FLOOR_FIRST) begin
                        car_at = car_at - 4'd1;
                    end
                    lamp_r = !has_riders;
                    lamp_g = 1'b0;
                end
                if (car_mode == MODE_FORCE) begin
                    lamp_g   = 1'b0;
                    lamp_r   = 1'b0;
                    lamp_y   = 1'b1;
                    lamp_bz  = 1'b1;
                    car_mode = MODE_MOVING;
                end else begin
                    lamp_y  = 1'b0;
                    lamp_bz = 1'b0;
                end
                if (car_mode == MODE_IDLE) begin
                    if (idle_run > idle_limit) begin
                        car_mode = MODE_MOVING;
                        idle_run = 5'd0;
                    end
                    if (idle_run < WAIT_MAX) idle_run = idle_run + 5'd1;
                end
            end
            REQ_KEY: begin
                if (key >= KEY_ONE && key <= KEY_NINE) begin
                    fl = 4'(key - KEY_ZERO);
                    if (fl <= FLOOR_TOP) begin
                        if (backlog >= QUEUE_DEPTH) begin
                            drop = 1'b1;
                        end else begin
                            floor_calls[wr_ptr] = fl;
                            wr_ptr  = 4'((wr_ptr + 1) % QUEUE_DEPTH);
                            backlog = backlog + 5'd1;
                        end
                    end
                end else if (key == KEY_HOLD) begin
                    car_mode = MODE_HELD;
                end else if (key == KEY_CLOSE) begin
                    car_mode = MODE_MOVING;
                    idle_run = 5'd0;
                end
            end
            REQ_RELEASE: begin
                if (car_mode == MODE_HELD || car_mode == MODE_FORCE) car_mode = MODE_MOVING;
            end
            default: begin
                if (car_mode == MODE_HELD) car_mode = MODE_FORCE;
            end
        endcase
        r.floor_now       = car_at;
        r.going_down      = car_down;
        r.motion_mode     = car_mode;
        r.green_on        = lamp_g;
        r.red_on          = lamp_r;
        r.yellow_on       = lamp_y;
        r.buzzer_on       = lamp_bz;
        r.green_pattern   = pat;
        r.pending_count   = backlog;
        r.request_dropped = drop;
        return r;
    endfunction

    // Per-word random pause, with occasional runs of back-to-back words
    function automatic int draw_pause(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic bit link_idle();
        return car_events.size() == 0 && !req_ch.valid && car_reports_due.size() == 0;
    endfunction

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            $display("MISMATCH word %0d %s: got %0d, expected %0d",
                     reports_seen, name, got, want);
            mismatches++;
        end
    endtask

    task automatic add_event(input logic [1:0] kind, input logic [7:0] key);
        car_events.push_back('{kind: kind, key: key});
    endtask

    task automatic add_floor_key();
        add_event(REQ_KEY, KEY_ZERO + 8'($urandom_range(1, TOP_FLOOR)));
    endtask

    task automatic add_tick();
        add_event(REQ_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Mostly well-formed traffic: ticks, floor calls, holds; a little noise
    task automatic queue_random_traffic(input int count);
        int added;
        int pick;
        int n;
        added = 0;
        while (added < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                // burst of calls, often enough to overflow the queue
                n = $urandom_range(14, 20);
                repeat (n) add_floor_key();
                added += n;
            end else if (pick < 12) begin
                // door hold, some ticks, maybe a timeout, then maybe a release
                add_event(REQ_KEY, KEY_HOLD);
                n = $urandom_range(0, 3);
                repeat (n) add_tick();
                added += n + 1;
                if ($urandom_range(0, 1)) begin
                    add_event(REQ_TIMEOUT, 8'($urandom_range(0, 255)));
                    added++;
                    if ($urandom_range(0, 1)) begin
                        add_tick();
                        added++;
                    end
                end
                if ($urandom_range(0, 3) != 0) begin
                    add_event(REQ_RELEASE, 8'($urandom_range(0, 255)));
                    added++;
                end
            end else begin
                if (pick < 62)      add_tick();
                else if (pick < 82) add_floor_key();
                else if (pick < 86) add_event(REQ_KEY, KEY_CLOSE);
                else if (pick < 89) add_event(REQ_KEY, KEY_HOLD);
                else if (pick < 92) add_event(REQ_RELEASE, 8'($urandom_range(0, 255)));
                else if (pick < 95) add_event(REQ_TIMEOUT, 8'($urandom_range(0, 255)));
                else add_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                added++;
            end
        end
    endtask

    // Write idle_ticks once both channels have drained
    task automatic set_idle_ticks(input logic [3:0] value);
        do @(negedge i_clk); while (!link_idle());
        repeat (2) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        idle_limit     = value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    // Request word driver
    always @(posedge i_clk) begin
        t_car_event ev;
        logic       have_word;
        int         wait_left;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            tx_wait      <= 0;
        end else begin
            have_word = req_ch.valid;
            wait_left = tx_wait;
            if (req_ch.valid && req_ch.ready) begin
                car_reports_due.push_back(advance_car(req_ch.req_type, req_ch.key_code));
                have_word = 1'b0;
                wait_left = draw_pause(tx_calm);
            end
            if (!have_word) begin
                if (wait_left > 0) begin
                    wait_left--;
                end else if (car_events.size() > 0) begin
                    ev = car_events.pop_front();
                    req_ch.req_type <= ev.kind;
                    req_ch.key_code <= ev.key;
                    have_word = 1'b1;
                end
            end
            req_ch.valid <= have_word;
            tx_wait      <= wait_left;
        end
    end

    // Result word monitor
    always @(posedge i_clk) begin
        t_result want;
        logic    take;
        int      wait_left;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            rx_wait      <= 0;
        end else begin
            take      = res_ch.ready;
            wait_left = rx_wait;
            if (res_ch.valid && res_ch.ready) begin
                if (car_reports_due.size() == 0) begin
                    check_field("word with nothing due", 1, 0);
                end else begin
                    want = car_reports_due.pop_front();
                    check_field("floor_now", res_ch.floor_now, want.floor_now);
                    check_field("going_down", res_ch.going_down, want.going_down);
                    check_field("motion_mode", res_ch.motion_mode, want.motion_mode);
                    check_field("green_on", res_ch.green_on, want.green_on);
                    check_field("red_on", res_ch.red_on, want.red_on);
                    check_field("yellow_on", res_ch.yellow_on, want.yellow_on);
                    check_field("buzzer_on", res_ch.buzzer_on, want.buzzer_on);
                    check_field("green_pattern", res_ch.green_pattern, want.green_pattern);
                    check_field("pending_count", res_ch.pending_count, want.pending_count);
                    check_field("request_dropped", res_ch.request_dropped,
                                want.request_dropped);
                end
                reports_seen++;
                wait_left = draw_pause(rx_calm);
                take      = (wait_left == 0);
            end else if (!take) begin
                if (wait_left > 0) wait_left--;
                else take = 1'b1;
            end
            res_ch.ready <= take;
            rx_wait      <= wait_left;
        end
    end

    // Watchdog: no word moving on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = 4'd0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_TICK;
        req_ch.key_code = 8'd0;
        res_ch.ready    = 1'b0;
        idle_cycles     = 0;

        // predictor starts from the reset state
        wr_ptr       = '0;
        rd_ptr       = '0;
        backlog      = '0;
        car_at       = FLOOR_FIRST;
        car_goal     = FLOOR_FIRST;
        car_down     = 1'b0;
        car_mode     = MODE_IDLE;
        idle_run     = '0;
        pickup_half  = 1'b0;
        has_riders   = 1'b0;
        arrival_done = 1'b0;
        {lamp_g, lamp_r, lamp_y, lamp_bz} = 4'b0;
        idle_limit   = IDLE_TICKS_RST;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: arrival at rest, ignored keys, holds, force close
        add_event(REQ_TICK, 8'h00);
        add_event(REQ_TICK, 8'hFF);
        add_event(REQ_KEY, 8'h00);
        add_event(REQ_KEY, 8'hFF);
        add_event(REQ_KEY, KEY_ONE - 8'd1);
        add_event(REQ_KEY, KEY_NINE + 8'd1);
        add_event(REQ_RELEASE, 8'h00);
        add_event(REQ_TIMEOUT, 8'hFF);
        add_event(REQ_KEY, KEY_NINE);
        add_event(REQ_KEY, KEY_ONE);
        add_event(REQ_TICK, 8'h00);
        add_event(REQ_KEY, KEY_CLOSE);
        add_event(REQ_TICK, 8'h00);
        add_event(REQ_KEY, KEY_HOLD);
        add_event(REQ_TICK, 8'h00);       // tick while the door is held
        add_event(REQ_TIMEOUT, 8'h00);
        add_event(REQ_TIMEOUT, 8'h00);    // already forcing, no effect
        add_event(REQ_TICK, 8'h00);       // force close: yellow and buzzer
        add_event(REQ_KEY, KEY_HOLD);
        add_event(REQ_RELEASE, 8'hFF);
        add_event(REQ_RELEASE, 8'h00);    // release while moving, ignored
        repeat (3) add_event(REQ_TICK, 8'h00);

        // Random phases over several idle_ticks settings, extremes first
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0)      set_idle_ticks(4'd0);
            else if (p == 1) set_idle_ticks(4'd15);
            else             set_idle_ticks(4'($urandom_range(0, 15)));
            queue_random_traffic(PHASE_WORDS);
        end

        do @(negedge i_clk); while (!link_idle());
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        check_field("results still due", car_reports_due.size(), 0);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
